// File: sv/rhmt_pkg.sv
// ----------------------------------------------------------------------------
// rhmt_pkg: shared types and constants for the mapping table
// Entry layout, command and status codes, default geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package rhmt_pkg;

	localparam int unsigned HASH_BITS_DEF = 10;
	localparam int unsigned WAYS_DEF      = 4;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_RELEASE  = 2'd1,
		CMD_QUERY    = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_SAT   = 2'd2,
		STAT_STALE = 2'd3
	} status_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] dev;
		logic [63:0] inode;
		logic [62:0] offset;
		logic [63:0] length;
		logic [31:0] count;
	} entry_t;

endpackage

`default_nettype wire

// File: sv/rhmt_slot_store.sv
// ----------------------------------------------------------------------------
// rhmt_slot_store: entry memory
// One write port and one registered read port over all table entries.
// ----------------------------------------------------------------------------
`default_nettype none

module rhmt_slot_store #(
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = 12
) (
	input  wire logic               clk,
	input  wire logic               rd_en,
	input  wire logic [ADDR_W-1:0]  rd_addr,
	output rhmt_pkg::entry_t        rd_data,
	input  wire logic               wr_en,
	input  wire logic [ADDR_W-1:0]  wr_addr,
	input  wire rhmt_pkg::entry_t   wr_data
);
	import rhmt_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: sv/refcounted_hashed_mapping_table.sv
// ----------------------------------------------------------------------------
// refcounted_hashed_mapping_table: reference-counted hashed key table
// Set-associative table of (dev, inode, offset, length) keys with counts.
// ----------------------------------------------------------------------------
// After reset the block sweeps the entry memory to clear the valid marks, one
// entry per cycle, over all (1 << HASH_BITS) * WAYS entries (4096 by default),
// with s_axis_tready low. Then it takes one item at a time. A register command
// passes the accepting state, hashing in the shared multiply-by-31 step unit,
// a read and a compare state per way probed through the single registered
// memory read port (up to WAYS ways), a write state unless saturated or full,
// and a done state that hands the result on. Release and query read the handle's
// entry and compare it, and release writes a live one back; a null handle, a
// handle beyond the table or the unused command go straight to done. A finished
// result sits in the output register, so the next item is accepted while it waits.
`default_nettype none

module refcounted_hashed_mapping_table #(
	parameter int unsigned HASH_BITS = rhmt_pkg::HASH_BITS_DEF,
	parameter int unsigned WAYS      = rhmt_pkg::WAYS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// dev_id[31:0], inode_num[95:32], map_offset[158:96], map_length[222:159],
	// handle[234:223], zero pad[239:235]
	input  wire logic [239:0] s_axis_tdata,
	// cmd[1:0], handle_present[2]
	input  wire logic [2:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// entry_handle[11:0], ref_count[43:12], zero pad[47:44]
	output logic [47:0]       m_axis_tdata,
	// status[1:0], freed[2]
	output logic [2:0]        m_axis_tuser
);
	import rhmt_pkg::*;

	localparam int unsigned NUM_SLOTS = (1 << HASH_BITS) * WAYS;
	localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
	localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [WAY_W-1:0]  WAY_LAST  = WAY_W'(WAYS - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_HASH  = 7'b0000100,
		S_RD    = 7'b0001000,
		S_CMP   = 7'b0010000,
		S_WR    = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// input field views
	logic [31:0] in_dev;
	logic [63:0] in_ino;
	logic [62:0] in_off;
	logic [63:0] in_len;
	logic [11:0] in_handle;
	cmd_t        in_cmd;
	logic        in_present;

	assign in_dev     = s_axis_tdata[31:0];
	assign in_ino     = s_axis_tdata[95:32];
	assign in_off     = s_axis_tdata[158:96];
	assign in_len     = s_axis_tdata[222:159];
	assign in_handle  = s_axis_tdata[234:223];
	assign in_cmd     = cmd_t'(s_axis_tuser[1:0]);
	assign in_present = s_axis_tuser[2];

	// latched item
	cmd_t        cmd_q;
	logic [31:0] dev_q;
	logic [63:0] ino_q;
	logic [62:0] off_q;
	logic [63:0] len_q;
	logic [11:0] handle_q;

	// sequencer state
	logic [HASH_BITS-1:0] h_q;
	logic [1:0]           step_q;
	logic [WAY_W-1:0]     way_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    clr_q;
	logic                 have_free_q;
	logic [SLOT_W-1:0]    free_slot_q;
	logic [SLOT_W-1:0]    wr_addr_q;
	entry_t               wr_data_q;

	// pending result
	status_t     res_status_q;
	logic [11:0] res_handle_q;
	logic [31:0] res_count_q;
	logic        res_freed_q;

	// output register
	logic        m_valid_q;
	status_t     m_status_q;
	logic [11:0] m_handle_q;
	logic [31:0] m_count_q;
	logic        m_freed_q;

	// shared hash step: h * 31 + x, kept to the bucket bits
	logic [HASH_BITS-1:0] hash_x;
	logic [HASH_BITS-1:0] hash_next;

	always_comb begin
		case (step_q)
			2'd0:    hash_x = ino_q[HASH_BITS-1:0];
			2'd1:    hash_x = off_q[HASH_BITS-1:0];
			default: hash_x = len_q[HASH_BITS-1:0];
		endcase
	end

	assign hash_next = HASH_BITS'((h_q << 5) - h_q + hash_x);

	// entry memory
	entry_t            rd_data;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	entry_t            mem_wdata;

	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WR);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : wr_addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : wr_data_q;

	rhmt_slot_store #(
		.DEPTH  (NUM_SLOTS),
		.ADDR_W (SLOT_W)
	) u_store (
		.clk     (clk),
		.rd_en   (state_q == S_RD),
		.rd_addr (slot_q),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	// probe decode
	logic        key_hit;
	logic        free_now;
	logic [31:0] cnt_adj;
	logic        out_free;

	assign key_hit  = rd_data.valid && (rd_data.dev == dev_q) && (rd_data.inode == ino_q)
		&& (rd_data.offset == off_q) && (rd_data.length == len_q);
	assign free_now = !rd_data.valid;
	// one adder serves both increment and decrement
	assign cnt_adj  = rd_data.count + ((cmd_q == CMD_REGISTER) ? 32'd1 : 32'hFFFF_FFFF);
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			way_q       <= '0;
			have_free_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						step_q      <= '0;
						way_q       <= '0;
						have_free_q <= 1'b0;
						if (in_cmd == CMD_REGISTER) begin
							state_q <= S_HASH;
						end else if (in_cmd == CMD_NOP || !in_present
							|| 32'(in_handle) >= 32'(NUM_SLOTS)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_HASH: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmd_q == CMD_REGISTER) begin
						if (key_hit) begin
							state_q <= (rd_data.count == COUNT_MAX) ? S_DONE : S_WR;
						end else begin
							if (!have_free_q && free_now) begin
								have_free_q <= 1'b1;
							end
							if (way_q == WAY_LAST) begin
								state_q <= (have_free_q || free_now) ? S_WR : S_DONE;
							end else begin
								way_q   <= way_q + 1'b1;
								state_q <= S_RD;
							end
						end
					end else if (!rd_data.valid || cmd_q == CMD_QUERY) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// payload and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd_q       <= in_cmd;
					dev_q       <= in_dev;
					ino_q       <= in_ino;
					off_q       <= in_off;
					len_q       <= in_len;
					handle_q    <= in_handle;
					h_q         <= in_dev[HASH_BITS-1:0];
					slot_q      <= SLOT_W'(32'(in_handle));
					res_freed_q <= 1'b0;
					if ((in_cmd == CMD_RELEASE || in_cmd == CMD_QUERY) && in_present
						&& 32'(in_handle) >= 32'(NUM_SLOTS)) begin
						res_status_q <= STAT_STALE;
						res_handle_q <= in_handle;
					end else begin
						res_status_q <= STAT_OK;
						res_handle_q <= '0;
					end
					// a null query reports a count of one
					if (in_cmd == CMD_QUERY && !in_present) begin
						res_count_q <= 32'd1;
					end else begin
						res_count_q <= '0;
					end
				end
			end
			S_HASH: begin
				h_q <= hash_next;
				if (step_q == 2'd2) begin
					slot_q <= SLOT_W'(hash_next) * SLOT_W'(WAYS);
				end
			end
			S_CMP: begin
				if (cmd_q == CMD_REGISTER) begin
					if (key_hit) begin
						res_handle_q <= 12'(slot_q);
						wr_addr_q    <= slot_q;
						if (rd_data.count == COUNT_MAX) begin
							res_status_q <= STAT_SAT;
							res_count_q  <= rd_data.count;
						end else begin
							res_status_q <= STAT_OK;
							res_count_q  <= cnt_adj;
							wr_data_q    <= '{valid: 1'b1, dev: rd_data.dev,
								inode: rd_data.inode, offset: rd_data.offset,
								length: rd_data.length, count: cnt_adj};
						end
					end else begin
						if (!have_free_q && free_now) begin
							free_slot_q <= slot_q;
						end
						if (way_q == WAY_LAST) begin
							if (have_free_q || free_now) begin
								wr_addr_q    <= have_free_q ? free_slot_q : slot_q;
								wr_data_q    <= '{valid: 1'b1, dev: dev_q, inode: ino_q,
									offset: off_q, length: len_q, count: 32'd1};
								res_status_q <= STAT_OK;
								res_handle_q <= 12'(have_free_q ? free_slot_q : slot_q);
								res_count_q  <= 32'd1;
							end else begin
								res_status_q <= STAT_FULL;
								res_handle_q <= '0;
								res_count_q  <= '0;
							end
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end else begin
					res_handle_q <= handle_q;
					wr_addr_q    <= slot_q;
					if (!rd_data.valid) begin
						res_status_q <= STAT_STALE;
						res_count_q  <= '0;
					end else if (cmd_q == CMD_QUERY) begin
						res_count_q <= rd_data.count;
					end else begin
						res_count_q <= cnt_adj;
						res_freed_q <= (cnt_adj == '0);
						wr_data_q   <= '{valid: (cnt_adj != '0), dev: rd_data.dev,
							inode: rd_data.inode, offset: rd_data.offset,
							length: rd_data.length, count: cnt_adj};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_status_q <= res_status_q;
			m_handle_q <= res_handle_q;
			m_count_q  <= res_count_q;
			m_freed_q  <= res_freed_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, m_count_q, m_handle_q};
	assign m_axis_tuser  = {m_freed_q, m_status_q};

	// one item in flight: accepting closes the input for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while another is in work");

	// a freed entry reports a clean zero count
	a_freed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |->
		m_axis_tuser[1:0] == STAT_OK && m_axis_tdata[43:12] == 32'd0)
		else $error("freed result with nonzero count or error status");

	// a full bucket reports no handle and no count
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == STAT_FULL |-> m_axis_tdata == 48'd0)
		else $error("bucket full result carries data");

	// the clearing sweep ends exactly after the last entry
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR && clr_q == SLOT_LAST |=> state_q == S_IDLE)
		else $error("clearing sweep did not finish");

endmodule

`default_nettype wire
